// ===== hdl/itch_add_order_stream_parser_macros.svh =====
// Assertion helpers for the add-order parser.
`ifndef ITCH_ADD_ORDER_STREAM_PARSER_MACROS_SVH
`define ITCH_ADD_ORDER_STREAM_PARSER_MACROS_SVH

// Same-cycle implication under reset gating.
`define IAOSP_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("implication check failed");

// Next-cycle implication under reset gating.
`define IAOSP_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/iaosp_pkg.sv =====
package iaosp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned RefW    = 64;
  localparam int unsigned SideW   = 8;
  localparam int unsigned SharesW = 32;
  localparam int unsigned SymW    = 64;
  localparam int unsigned PriceW  = 32;
  localparam int unsigned ResW    = RefW + SideW + SharesW + SymW + PriceW;

  localparam logic [ByteW-1:0] KindAdd     = 8'h41;
  localparam logic [ByteW-1:0] KindAddAttr = 8'h46;

  localparam logic [LenW-1:0] OfsReference = 16'd11;
  localparam logic [LenW-1:0] OfsSide      = 16'd19;
  localparam logic [LenW-1:0] OfsShares    = 16'd20;
  localparam logic [LenW-1:0] OfsSymbol    = 16'd24;
  localparam logic [LenW-1:0] OfsPrice     = 16'd32;
  localparam logic [LenW-1:0] OfsEnd       = 16'd36;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'b001,
    PH_LEN_LO = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [PriceW-1:0]  order_price;
    logic [SymW-1:0]    stock_symbol;
    logic [SharesW-1:0] share_count;
    logic [SideW-1:0]   order_side;
    logic [RefW-1:0]    order_reference;
  } order_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

// ===== hdl/iaosp_parser.sv =====
module iaosp_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [iaosp_pkg::ByteW-1:0] data_byte,
  output logic                   res_valid,
  output iaosp_pkg::order_t      res
);
  import iaosp_pkg::*;

  phase_t              phase, phase_next;
  logic [LenW-1:0]     body_length, body_length_next;
  logic [LenW-1:0]     body_position, body_position_next;
  logic [ByteW-1:0]    message_kind, message_kind_next;
  logic [RefW-1:0]     held_reference, held_reference_next;
  logic [SideW-1:0]    held_side, held_side_next;
  logic [SharesW-1:0]  held_shares, held_shares_next;
  logic [SymW-1:0]     held_symbol, held_symbol_next;
  logic [PriceW-1:0]   held_price, held_price_next;
  logic [LenW:0]       pos_inc;
  logic                last;

  assign pos_inc = {1'b0, body_position} + {{LenW{1'b0}}, 1'b1};
  assign last    = pos_inc >= {1'b0, body_length};

  always_comb begin
    phase_next          = phase;
    body_length_next    = body_length;
    body_position_next  = body_position;
    message_kind_next   = message_kind;
    held_reference_next = held_reference;
    held_side_next      = held_side;
    held_shares_next    = held_shares;
    held_symbol_next    = held_symbol;
    held_price_next     = held_price;
    res_valid           = 1'b0;
    if (accept) begin
      case (phase)
        PH_LEN_LO: begin
          body_length_next = {body_length[LenW-1:ByteW], data_byte};
          if (body_length_next == '0) begin
            phase_next = PH_LEN_HI;
          end else begin
            phase_next          = PH_BODY;
            body_position_next  = '0;
            message_kind_next   = '0;
            held_reference_next = '0;
            held_side_next      = '0;
            held_shares_next    = '0;
            held_symbol_next    = '0;
            held_price_next     = '0;
          end
        end
        PH_BODY: begin
          if (body_position == '0) begin
            message_kind_next = data_byte;
          end
          if (body_position >= OfsReference && body_position < OfsSide) begin
            held_reference_next = {held_reference[RefW-ByteW-1:0], data_byte};
          end else if (body_position == OfsSide) begin
            held_side_next = data_byte;
          end else if (body_position >= OfsShares && body_position < OfsSymbol) begin
            held_shares_next = {held_shares[SharesW-ByteW-1:0], data_byte};
          end else if (body_position >= OfsSymbol && body_position < OfsPrice) begin
            held_symbol_next = {held_symbol[SymW-ByteW-1:0], data_byte};
          end else if (body_position >= OfsPrice && body_position < OfsEnd) begin
            held_price_next = {held_price[PriceW-ByteW-1:0], data_byte};
          end
          body_position_next = pos_inc[LenW-1:0];
          if (last) begin
            phase_next = PH_LEN_HI;
            res_valid  = (message_kind_next == KindAdd) || (message_kind_next == KindAddAttr);
          end
        end
        default: begin
          body_length_next = {data_byte, {ByteW{1'b0}}};
          phase_next       = PH_LEN_LO;
        end
      endcase
    end
  end

  assign res.order_reference = held_reference_next;
  assign res.order_side      = held_side_next;
  assign res.share_count     = held_shares_next;
  assign res.stock_symbol    = held_symbol_next;
  assign res.order_price     = held_price_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN_HI;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    body_length    <= body_length_next;
    body_position  <= body_position_next;
    message_kind   <= message_kind_next;
    held_reference <= held_reference_next;
    held_side      <= held_side_next;
    held_shares    <= held_shares_next;
    held_symbol    <= held_symbol_next;
    held_price     <= held_price_next;
  end

endmodule

// ===== hdl/iaosp_out_buf.sv =====
module iaosp_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  iaosp_pkg::order_t      push_data,
  input  logic                   pop_ready,
  output logic                   out_valid,
  output iaosp_pkg::order_t      out_data,
  output logic                   space,
  output iaosp_pkg::buf_status_t status
);
  import iaosp_pkg::*;

  logic   main_valid, skid_valid;
  order_t main_data, skid_data;
  logic   pop;

  assign pop       = main_valid && pop_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign space     = !skid_valid;
  assign status.main_valid = main_valid;
  assign status.skid_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

// ===== hdl/itch_add_order_stream_parser.sv =====
// Length-framed market-data parser for add-order messages. One stream byte is
// taken per cycle, every cycle, as long as the output side is not backed up by
// two results; the frame state and field capture update in the same cycle the
// byte transfers. An add-order message (type A or F) yields one result in the
// output register on the cycle after its last body byte transfers, or waits in
// a skid register while the output register is full; s_tready drops only when
// both are full. There is no startup sweep: the block is ready out of reset.
module itch_add_order_stream_parser
  `include "itch_add_order_stream_parser_macros.svh"
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // data_byte[7:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // order_reference[63:0], order_side[71:64], share_count[103:72],
  // stock_symbol[167:104], order_price[199:168]
  output logic [iaosp_pkg::ResW-1:0]     m_tdata
);
  import iaosp_pkg::*;

  logic        accept;
  logic        res_valid;
  order_t      res;
  order_t      out_data;
  buf_status_t status;

  assign accept = s_tvalid && s_tready;

  iaosp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  iaosp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .space     (s_tready),
    .status    (status)
  );

  assign m_tdata = out_data;

  `IAOSP_ASSERT_IMPLY(a_skid_behind_main, clk, rst, status.skid_valid, status.main_valid)
  `IAOSP_ASSERT_IMPLY(a_stall_needs_result, clk, rst, !s_tready, m_tvalid)
  `IAOSP_ASSERT_NEXT(a_empty_after_reset, clk, 1'b0, rst, !m_tvalid && s_tready)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import iaosp_pkg::*;

  localparam int StallLimit = 4000;
  localparam int RxHoldCycles = 400;
  localparam int RandomBytes = 1050;
  localparam logic [7:0] SideBuy = 8'h42;
  localparam logic [7:0] SideSell = 8'h53;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONE} fill_t;

  class order_tracker;
    phase_t phase;
    logic [LenW-1:0] body_len;
    logic [LenW-1:0] body_pos;
    logic [ByteW-1:0] kind;
    order_t held;
    order_t pending_orders[$];
    int mismatches;

    function new();
      phase = PH_LEN_HI;
      body_len = '0;
      body_pos = '0;
      kind = '0;
      held = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return pending_orders.size();
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      logic last;
      case (phase)
        PH_LEN_LO: begin
          body_len = {body_len[15:8], b};
          if (body_len == '0) begin
            phase = PH_LEN_HI;
          end else begin
            phase = PH_BODY;
            body_pos = '0;
            kind = '0;
            held = '0;
          end
        end
        PH_BODY: begin
          if (body_pos == '0) kind = b;
          if (body_pos >= OfsReference && body_pos < OfsSide)
            held.order_reference = {held.order_reference[RefW-9:0], b};
          else if (body_pos == OfsSide)
            held.order_side = b;
          else if (body_pos >= OfsShares && body_pos < OfsSymbol)
            held.share_count = {held.share_count[SharesW-9:0], b};
          else if (body_pos >= OfsSymbol && body_pos < OfsPrice)
            held.stock_symbol = {held.stock_symbol[SymW-9:0], b};
          else if (body_pos >= OfsPrice && body_pos < OfsEnd)
            held.order_price = {held.order_price[PriceW-9:0], b};
          last = ({1'b0, body_pos} + 17'd1) >= {1'b0, body_len};
          body_pos = body_pos + 16'd1;
          if (last) begin
            phase = PH_LEN_HI;
            if (kind == KindAdd || kind == KindAddAttr) pending_orders.push_back(held);
          end
        end
        default: begin
          body_len = {b, 8'h00};
          phase = PH_LEN_LO;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %h, actual %h", name, want, got);
      end
    endfunction

    function void check_order(order_t got);
      order_t want;
      if (pending_orders.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: unexpected result %h", got);
        return;
      end
      want = pending_orders.pop_front();
      compare_field("order_reference", want.order_reference, got.order_reference);
      compare_field("order_side", 64'(want.order_side), 64'(got.order_side));
      compare_field("share_count", 64'(want.share_count), 64'(got.share_count));
      compare_field("stock_symbol", want.stock_symbol, got.stock_symbol);
      compare_field("order_price", 64'(want.order_price), 64'(got.order_price));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [ResW-1:0] m_tdata;

  order_tracker tracker;
  int rx_hold_request;
  bit no_idle;
  int bytes_sent;

  itch_add_order_stream_parser i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = b;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(logic [15:0] len, logic [7:0] kind, fill_t fill);
    logic [7:0] b;
    int i;
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (i = 0; i < len; i++) begin
      if (i == 0) begin
        b = kind;
      end else begin
        case (fill)
          FILL_ZERO: b = 8'h00;
          FILL_ONE: b = 8'hFF;
          default: begin
            if (i == OfsSide && $urandom_range(0, 3) != 0)
              b = $urandom_range(0, 1) ? SideBuy : SideSell;
            else
              b = 8'($urandom);
          end
        endcase
      end
      send_byte(b);
    end
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] other_kind();
    logic [7:0] k;
    do k = 8'($urandom); while (k == KindAdd || k == KindAddAttr);
    return k;
  endfunction

  function automatic logic [7:0] add_kind();
    return $urandom_range(0, 1) ? KindAdd : KindAddAttr;
  endfunction

  // receiver
  initial begin
    int gap;
    int hold;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        hold = rx_hold_request;
        rx_hold_request = 0;
        m_tready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_order(order_t'(m_tdata));
      @(negedge clk);
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int r;
    int i;
    tracker = new();
    rx_hold_request = 0;
    no_idle = 1'b0;
    bytes_sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send_message(16'd0, 8'h00, FILL_RANDOM);
    send_message(16'd36, KindAdd, FILL_ONE);
    send_message(16'd36, KindAddAttr, FILL_ZERO);
    send_message(16'd36, KindAddAttr, FILL_RANDOM);
    send_message(16'd0, 8'h00, FILL_RANDOM);
    send_message(16'd40, KindAdd, FILL_RANDOM);
    send_message(16'd1, KindAdd, FILL_RANDOM);
    send_message(16'd15, KindAddAttr, FILL_RANDOM);
    send_message(16'd22, KindAdd, FILL_ONE);
    send_message(16'd34, KindAdd, FILL_RANDOM);
    send_message(16'd30, 8'h45, FILL_RANDOM);
    send_message(16'd36, 8'h00, FILL_ONE);
    send_message(16'd36, 8'hFF, FILL_RANDOM);
    send_message(16'd256, KindAdd, FILL_RANDOM);
    drain();

    i = 0;
    while (bytes_sent < RandomBytes) begin
      i++;
      if (i % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == 2) begin
        // stall the receiver and flood short add-orders to back up the input
        rx_hold_request = RxHoldCycles;
        repeat (24) send_message(16'd1, add_kind(), FILL_RANDOM);
      end
      if (i == 5) drain();
      r = $urandom_range(0, 99);
      if (r < 65)
        send_message(16'(36 + $urandom_range(0, 8)), add_kind(), FILL_RANDOM);
      else if (r < 82)
        send_message(16'($urandom_range(1, 35)), add_kind(), FILL_RANDOM);
      else if (r < 93)
        send_message(16'($urandom_range(0, 60)), other_kind(), FILL_RANDOM);
      else
        send_message(16'd0, 8'h00, FILL_RANDOM);
    end

    no_idle = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
